// ----- sv/hat_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hat_pkg: shared definitions for the handle table allocator
// Sizes, request and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package hat_pkg;

	// Memory and table sizing
	localparam int MEM_BYTES   = 4096;
	localparam int ENTRIES     = 64;
	localparam int TABLE_DEPTH = 64;
	localparam int HANDLE_W    = $clog2(TABLE_DEPTH);
	localparam int COUNT_W     = 7;
	localparam int LIVE_W      = 14;
	localparam int OFFSET_W    = 13;
	localparam int CLASS_W     = 3;
	localparam int SIZE_W      = 8;

	// Request codes
	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_FETCH = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOMEM   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_UNAVAIL = 2'd3;

	// Result payload select
	localparam logic [1:0] SEL_NONE = 2'd0;
	localparam logic [1:0] SEL_NEW  = 2'd1;
	localparam logic [1:0] SEL_HIT  = 2'd2;
	localparam logic [1:0] SEL_SUM  = 2'd3;

	// Commands from controller to datapath
	typedef struct packed {
		logic       load;
		logic       first_wr;
		logic       append_wr;
		logic       free_wr;
		logic       scan_start;
		logic       scan_run;
		logic       hit_take;
		logic       res_wr;
		logic [1:0] res_status;
		logic [1:0] res_sel;
		logic       emit;
	} hat_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [1:0] req_type;
		logic       first;
		logic       full;
		logic       fits;
		logic       live_h;
		logic       issue_done;
		logic       s1_valid;
		logic       hit;
		logic       out_free;
	} hat_stat_t;

	// Block size in bytes of a size class
	function automatic logic [SIZE_W-1:0] class_bytes(input logic [CLASS_W-1:0] c);
		class_bytes = SIZE_W'(1) << c;
	endfunction

endpackage
`default_nettype wire

// ----- sv/hat_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hat_if: request and response channels
// Valid/ready channels carrying one request word and one response word.
// ----------------------------------------------------------------------------
interface hat_req_if;
	import hat_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          req_type;
	logic [CLASS_W-1:0]  size_class;
	logic [HANDLE_W-1:0] handle;

	modport source (output valid, output req_type, output size_class, output handle,
		input ready);
	modport sink (input valid, input req_type, input size_class, input handle,
		output ready);
endinterface

interface hat_rsp_if;
	import hat_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic [HANDLE_W-1:0] handle_out;
	logic [OFFSET_W-1:0] byte_offset;

	modport source (output valid, output status, output handle_out, output byte_offset,
		input ready);
	modport sink (input valid, input status, input handle_out, input byte_offset,
		output ready);
endinterface
`default_nettype wire

// ----- sv/hat_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hat_ctrl: allocator sequencer
// Decodes a request, runs the table scan and hands the result word out.
// ----------------------------------------------------------------------------
module hat_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_ready,
	input  hat_pkg::hat_stat_t stat,
	output hat_pkg::hat_cmd_t  cmd
);
	import hat_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_FREE   = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_RESULT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_RESULT;
				case (stat.req_type)
					REQ_ALLOC: begin
						if (stat.first) begin
							cmd.first_wr   = 1'b1;
							cmd.res_wr     = 1'b1;
							cmd.res_status = ST_OK;
							cmd.res_sel    = SEL_NEW;
						end else if (stat.full) begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end else if (!stat.fits) begin
							cmd.res_wr     = 1'b1;
							cmd.res_status = ST_NOMEM;
						end else begin
							cmd.append_wr  = 1'b1;
							cmd.res_wr     = 1'b1;
							cmd.res_status = ST_OK;
							cmd.res_sel    = SEL_NEW;
						end
					end
					REQ_FREE: begin
						if (stat.live_h) begin
							state_d = S_FREE;
						end else begin
							cmd.res_wr     = 1'b1;
							cmd.res_status = ST_OK;
						end
					end
					REQ_FETCH: begin
						if (stat.live_h) begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end else begin
							cmd.res_wr     = 1'b1;
							cmd.res_status = ST_UNAVAIL;
						end
					end
					default: begin
						cmd.res_wr     = 1'b1;
						cmd.res_status = ST_UNAVAIL;
					end
				endcase
			end
			S_FREE: begin
				// class of the handle is now out of the table
				cmd.free_wr    = 1'b1;
				cmd.res_wr     = 1'b1;
				cmd.res_status = ST_OK;
				state_d        = S_RESULT;
			end
			S_SCAN: begin
				if (stat.hit) begin
					cmd.hit_take   = 1'b1;
					cmd.res_wr     = 1'b1;
					cmd.res_status = ST_OK;
					cmd.res_sel    = SEL_HIT;
					state_d        = S_RESULT;
				end else if (stat.issue_done && !stat.s1_valid) begin
					cmd.res_wr = 1'b1;
					if (stat.req_type == REQ_ALLOC) begin
						cmd.res_status = ST_FULL;
					end else begin
						cmd.res_status = ST_OK;
						cmd.res_sel    = SEL_SUM;
					end
					state_d = S_RESULT;
				end else begin
					cmd.scan_run = 1'b1;
				end
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- sv/hat_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hat_dp: allocator datapath
// Class table, free flags, counters, scan pipeline and output register.
// ----------------------------------------------------------------------------
module hat_dp (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  [1:0]                   in_req_type,
	input  wire  [hat_pkg::CLASS_W-1:0]  in_size_class,
	input  wire  [hat_pkg::HANDLE_W-1:0] in_handle,
	input  hat_pkg::hat_cmd_t            cmd,
	output hat_pkg::hat_stat_t           stat,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [1:0]                   out_status,
	output logic [hat_pkg::HANDLE_W-1:0] out_handle,
	output logic [hat_pkg::OFFSET_W-1:0] out_offset
);
	import hat_pkg::*;

	// Request word
	logic [1:0]          req_type_q;
	logic [CLASS_W-1:0]  class_q;
	logic [HANDLE_W-1:0] handle_q;

	// Table state
	logic [CLASS_W-1:0]     class_mem [TABLE_DEPTH];
	logic [CLASS_W-1:0]     rd_data_q;
	logic [TABLE_DEPTH-1:0] free_q;
	logic [COUNT_W-1:0]     count_q;
	logic [LIVE_W-1:0]      live_q;

	// Scan
	logic [COUNT_W-1:0]  cursor_q;
	logic                valid_s1;
	logic [HANDLE_W-1:0] idx_s1;
	logic [OFFSET_W-1:0] sum_q;

	// Result staging
	logic [1:0]          res_status_q;
	logic [HANDLE_W-1:0] res_handle_q;
	logic [OFFSET_W-1:0] res_offset_q;

	logic [SIZE_W-1:0]   size;
	logic [SIZE_W-1:0]   rd_bytes;
	logic [HANDLE_W-1:0] rd_addr;
	logic [HANDLE_W-1:0] wr_addr;
	logic [COUNT_W-1:0]  limit;
	logic [LIVE_W:0]     need;

	assign size     = class_bytes(class_q);
	assign rd_bytes = class_bytes(rd_data_q);
	assign rd_addr  = cmd.scan_run ? cursor_q[HANDLE_W-1:0] : handle_q;
	assign wr_addr  = count_q[HANDLE_W-1:0];
	assign limit    = (req_type_q == REQ_ALLOC) ? count_q : COUNT_W'(handle_q);
	assign need     = {1'b0, live_q} + (LIVE_W+1)'(size);

	// Status toward the controller
	always_comb begin
		stat.req_type   = req_type_q;
		stat.first      = (count_q == '0);
		stat.full       = (count_q >= COUNT_W'(ENTRIES - 1));
		stat.fits       = (need <= (LIVE_W+1)'(MEM_BYTES));
		stat.live_h     = (COUNT_W'(handle_q) < count_q) && !free_q[handle_q];
		stat.issue_done = (cursor_q >= limit);
		stat.s1_valid   = valid_s1;
		stat.hit        = valid_s1 && (req_type_q == REQ_ALLOC) && free_q[idx_s1]
			&& (rd_data_q == class_q);
		stat.out_free   = !out_valid || out_ready;
	end

	// Capture the request word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= in_req_type;
			class_q    <= in_size_class;
			handle_q   <= in_handle;
		end
	end

	// Class table: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (cmd.first_wr || cmd.append_wr) begin
			class_mem[wr_addr] <= class_q;
		end
		rd_data_q <= class_mem[rd_addr];
	end

	// Free flags, entry count and live byte total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q  <= '0;
			count_q <= '0;
			live_q  <= '0;
		end else begin
			if (cmd.first_wr) begin
				free_q[wr_addr] <= 1'b0;
				count_q         <= count_q + COUNT_W'(1);
				live_q          <= LIVE_W'(size);
			end else if (cmd.append_wr) begin
				free_q[wr_addr] <= 1'b0;
				count_q         <= count_q + COUNT_W'(1);
				live_q          <= live_q + LIVE_W'(size);
			end else if (cmd.hit_take) begin
				free_q[idx_s1] <= 1'b0;
				live_q         <= live_q + LIVE_W'(size);
			end else if (cmd.free_wr) begin
				free_q[handle_q] <= 1'b1;
				live_q           <= live_q - LIVE_W'(rd_bytes);
			end
		end
	end

	// Scan: issue one table read a cycle, check or sum it the next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			valid_s1 <= 1'b0;
			sum_q    <= '0;
		end else if (cmd.scan_start) begin
			cursor_q <= '0;
			valid_s1 <= 1'b0;
			sum_q    <= '0;
		end else if (cmd.scan_run) begin
			if (cursor_q < limit) begin
				cursor_q <= cursor_q + COUNT_W'(1);
				valid_s1 <= 1'b1;
			end else begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1) begin
				sum_q <= sum_q + OFFSET_W'(rd_bytes);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_run) begin
			idx_s1 <= cursor_q[HANDLE_W-1:0];
		end
	end

	// Stage the result word
	always_ff @(posedge clk) begin
		if (cmd.res_wr) begin
			res_status_q <= cmd.res_status;
			res_handle_q <= '0;
			res_offset_q <= '0;
			case (cmd.res_sel)
				SEL_NEW: res_handle_q <= wr_addr;
				SEL_HIT: res_handle_q <= idx_s1;
				SEL_SUM: res_offset_q <= sum_q;
				default: ;
			endcase
		end
	end

	// Output register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status <= res_status_q;
			out_handle <= res_handle_q;
			out_offset <= res_offset_q;
		end
	end

endmodule
`default_nettype wire

// ----- sv/handle_table_bump_allocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// handle_table_bump_allocator: handle table allocator with size classes
//
// Requests arrive on req (req_type, size_class, handle); exactly one
// response word per request leaves on rsp (status, handle_out, byte_offset).
// Both channels use valid/ready; a word moves when both are high.
//
// One request is in work at a time. The first grant, an append, a free of a
// handle that is not live and every immediate error answer go from decode
// straight to the result state; freeing a live handle passes a free state.
// Allocate on a full table and fetch walk the class table one entry per
// cycle over its single read port, up to the hit (reuse), the entry count
// (no match) or the handle number (fetch). The next request is accepted
// once the sequencer is back in idle after the response is loaded.
//
// Reset clears the entry count, live byte total and free flags; the class
// table itself is not cleared, since only handed-out entries are read.
// The response is held in an output register until the receiver takes it;
// the next request is accepted meanwhile and waits to report behind it.
// ----------------------------------------------------------------------------
module handle_table_bump_allocator (
	input  wire       clk,
	input  wire       arst_n,
	hat_req_if.sink   req,
	hat_rsp_if.source rsp
);
	import hat_pkg::*;

	hat_cmd_t  cmd;
	hat_stat_t stat;
	logic      ready;

	assign req.ready = ready;

	// Sequencer
	hat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Table and arithmetic
	hat_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_req_type   (req.req_type),
		.in_size_class (req.size_class),
		.in_handle     (req.handle),
		.cmd           (cmd),
		.stat          (stat),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.out_status    (rsp.status),
		.out_handle    (rsp.handle_out),
		.out_offset    (rsp.byte_offset)
	);

endmodule
`default_nettype wire

// ----- verif/tb_handle_table_bump_allocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_handle_table_bump_allocator: self-checking bench for the handle allocator
// Drives request words through named test phases (empty table, first grant
// and appends, memory exhaustion, table fill, reuse on a full table), keeps a
// software copy of the handle table to work out each response word, and
// checks every response field in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_handle_table_bump_allocator;
	import hat_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int WORD_BUDGET = 2000;
	localparam int DRAIN_CYCLES = 100;

	// Request code with no meaning
	localparam logic [1:0] REQ_UNDEF = 2'd3;

	typedef struct packed {
		logic [1:0]          status;
		logic [HANDLE_W-1:0] handle_out;
		logic [OFFSET_W-1:0] byte_offset;
	} answer_t;

	logic clk;
	logic arst_n;

	hat_req_if req_ch ();
	hat_rsp_if rsp_ch ();

	handle_table_bump_allocator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the handle table
	logic [CLASS_W-1:0] tbl_class [TABLE_DEPTH];
	bit                 tbl_free  [TABLE_DEPTH];
	int                 tbl_count;
	int                 tbl_live;

	// Responses owed by the block, oldest first
	answer_t owed_rsp [$];
	answer_t last_answer;

	bit pace_on;
	int err_count;
	int cycle_count;
	int words_sent;
	int words_checked;
	int status_seen [4];
	int reuse_grants;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle counter and timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb: timeout after %0d cycles", cycle_count);
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("tb: mismatch on %s: got %0d, want %0d (word %0d)", what, got, want,
			words_checked);
		err_count++;
	endtask

	// Advance the shadow table by one request and return the response it owes
	function automatic answer_t table_step(input logic [1:0] rt,
			input logic [CLASS_W-1:0] sc, input logic [HANDLE_W-1:0] h);
		answer_t a;
		int      sz;
		int      sum;
		bit      hit;
		a = '0;
		a.status = ST_OK;
		sz = 1 << sc;
		hit = 1'b0;
		case (rt)
			REQ_ALLOC: begin
				if (tbl_count == 0) begin
					// first grant skips the memory check
					tbl_class[0] = sc;
					tbl_free[0] = 1'b0;
					tbl_count = 1;
					tbl_live = sz;
				end else if (tbl_count >= ENTRIES - 1) begin
					// full table: take the lowest freed entry of this class
					for (int i = 0; i < tbl_count && !hit; i++) begin
						if (tbl_free[i] && tbl_class[i] == sc) begin
							tbl_free[i] = 1'b0;
							tbl_live = (tbl_live + sz) & 16'h3FFF;
							a.handle_out = HANDLE_W'(i);
							hit = 1'b1;
						end
					end
					if (hit)
						reuse_grants++;
					else
						a.status = ST_FULL;
				end else if (tbl_live + sz > MEM_BYTES) begin
					a.status = ST_NOMEM;
				end else begin
					tbl_class[tbl_count] = sc;
					tbl_free[tbl_count] = 1'b0;
					a.handle_out = HANDLE_W'(tbl_count);
					tbl_count++;
					tbl_live = (tbl_live + sz) & 16'h3FFF;
				end
			end
			REQ_FREE: begin
				if (int'(h) < tbl_count && !tbl_free[h]) begin
					tbl_free[h] = 1'b1;
					tbl_live -= 1 << tbl_class[h];
				end
			end
			REQ_FETCH: begin
				if (int'(h) >= tbl_count || tbl_free[h]) begin
					a.status = ST_UNAVAIL;
				end else begin
					// freed entries below still count toward the offset
					sum = 0;
					for (int i = 0; i < int'(h); i++)
						sum += 1 << tbl_class[i];
					a.byte_offset = OFFSET_W'(sum);
				end
			end
			default: a.status = ST_UNAVAIL;
		endcase
		status_seen[a.status]++;
		return a;
	endfunction

	// Send one request word; predict its response at acceptance
	task automatic send_word(input logic [1:0] rt, input logic [CLASS_W-1:0] sc,
			input logic [HANDLE_W-1:0] h);
		int gap;
		gap = pace_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= rt;
		req_ch.size_class <= sc;
		req_ch.handle     <= h;
		do @(posedge clk); while (!req_ch.ready);
		last_answer = table_step(rt, sc, h);
		owed_rsp.push_back(last_answer);
		words_sent++;
	endtask

	// Pick a handle that is live now, falling back to any handle
	function automatic logic [HANDLE_W-1:0] pick_live();
		logic [HANDLE_W-1:0] h;
		for (int t = 0; t < 16; t++) begin
			h = HANDLE_W'($urandom_range(0, tbl_count > 0 ? tbl_count - 1 : 0));
			if (int'(h) < tbl_count && !tbl_free[h])
				return h;
		end
		return HANDLE_W'($urandom_range(0, TABLE_DEPTH - 1));
	endfunction

	// Pick the class of some freed entry so that an allocate can reuse it
	function automatic logic [CLASS_W-1:0] pick_reuse_class();
		int i;
		for (int t = 0; t < 16; t++) begin
			i = $urandom_range(0, tbl_count > 0 ? tbl_count - 1 : 0);
			if (i < tbl_count && tbl_free[i])
				return tbl_class[i];
		end
		return CLASS_W'($urandom_range(0, 7));
	endfunction

	// One random request word; reuse_pct steers allocates toward freed classes
	task automatic send_random(input int reuse_pct);
		int                  r;
		logic [CLASS_W-1:0]  sc;
		logic [HANDLE_W-1:0] h;
		r = $urandom_range(0, 99);
		sc = CLASS_W'($urandom_range(0, 7));
		h = HANDLE_W'($urandom_range(0, TABLE_DEPTH - 1));
		if (r < reuse_pct)
			send_word(REQ_ALLOC, pick_reuse_class(), h);
		else if (r < 45)
			send_word(REQ_ALLOC, tbl_live > 3500 ? CLASS_W'($urandom_range(0, 4)) : sc, h);
		else if (r < 65)
			send_word(REQ_FREE, sc, pick_live());
		else if (r < 70)
			send_word(REQ_FREE, sc, h);
		else if (r < 90)
			send_word(REQ_FETCH, sc, pick_live());
		else if (r < 96)
			send_word(REQ_FETCH, sc, h);
		else
			send_word(REQ_UNDEF, sc, h);
	endtask

	// Switch idling on or off now and then
	task automatic maybe_repace();
		if (words_sent % 120 == 0)
			pace_on = ($urandom_range(0, 3) != 0);
	endtask

	// Response side: stall at random, then check the word against the oldest owed one
	initial begin : rsp_check
		answer_t want;
		int      stall;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = pace_on ? $urandom_range(0, 11) : 0;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			if (owed_rsp.size() == 0) begin
				report_mismatch("unrequested response status", int'(rsp_ch.status), 0);
			end else begin
				want = owed_rsp.pop_front();
				if (rsp_ch.status !== want.status)
					report_mismatch("status", int'(rsp_ch.status), int'(want.status));
				if (rsp_ch.handle_out !== want.handle_out)
					report_mismatch("handle_out", int'(rsp_ch.handle_out),
						int'(want.handle_out));
				if (rsp_ch.byte_offset !== want.byte_offset)
					report_mismatch("byte_offset", int'(rsp_ch.byte_offset),
						int'(want.byte_offset));
			end
			words_checked++;
		end
	end

	// Requests on an empty table
	task automatic test_empty_table();
		send_word(REQ_FETCH, 3'd0, 6'd0);
		send_word(REQ_FREE, 3'd0, 6'd5);
		send_word(REQ_FETCH, 3'd7, 6'd63);
		send_word(REQ_UNDEF, 3'd7, 6'd63);
	endtask

	// First grant, appends, offsets, free and double free
	task automatic test_first_and_append();
		send_word(REQ_ALLOC, 3'd7, 6'd63);
		send_word(REQ_ALLOC, 3'd0, 6'd0);
		send_word(REQ_ALLOC, 3'd3, 6'd42);
		send_word(REQ_FETCH, 3'd0, 6'd0);
		send_word(REQ_FETCH, 3'd0, 6'd1);
		send_word(REQ_FETCH, 3'd7, 6'd2);
		send_word(REQ_FETCH, 3'd0, 6'd3);
		send_word(REQ_FREE, 3'd5, 6'd1);
		send_word(REQ_FREE, 3'd5, 6'd1);
		send_word(REQ_FETCH, 3'd0, 6'd1);
		send_word(REQ_FETCH, 3'd0, 6'd2);
		send_word(REQ_FREE, 3'd0, 6'd40);
		send_word(REQ_UNDEF, 3'd0, 6'd21);
	endtask

	// Exhaust memory with large blocks, then fill it to the exact byte
	task automatic test_memory_limit();
		int nomem;
		int iter;
		nomem = 0;
		iter = 0;
		while (nomem < 4 && iter < 200 && tbl_count < ENTRIES - 1) begin
			if ($urandom_range(0, 4) == 0) begin
				send_word(REQ_FETCH, CLASS_W'($urandom_range(0, 7)), pick_live());
			end else begin
				send_word(REQ_ALLOC, CLASS_W'($urandom_range(5, 7)),
					HANDLE_W'($urandom_range(0, 63)));
				if (last_answer.status == ST_NOMEM)
					nomem++;
			end
			iter++;
		end
		// descending classes close the remaining gap bit by bit
		for (int c = 7; c >= 0; c--)
			send_word(REQ_ALLOC, CLASS_W'(c), HANDLE_W'($urandom_range(0, 63)));
		send_word(REQ_ALLOC, 3'd0, 6'd0);
		send_word(REQ_FETCH, 3'd0, pick_live());
	endtask

	// Random traffic until the table holds its last appendable entry
	task automatic test_fill_table();
		int iter;
		iter = 0;
		while (tbl_count < ENTRIES - 1 && iter < 1500) begin
			maybe_repace();
			send_random(0);
			iter++;
		end
		// append the rest directly if random traffic fell short
		while (tbl_count < ENTRIES - 1) begin
			if (tbl_live > MEM_BYTES - 1)
				send_word(REQ_FREE, 3'd0, pick_live());
			else
				send_word(REQ_ALLOC, 3'd0, HANDLE_W'($urandom_range(0, 63)));
		end
	endtask

	// Full table: reuse by class, table-full answers, frees and fetches
	task automatic test_table_full_reuse();
		while (words_sent < WORD_BUDGET) begin
			maybe_repace();
			send_random(30);
		end
	endtask

	initial begin
		req_ch.valid      <= 1'b0;
		req_ch.req_type   <= REQ_ALLOC;
		req_ch.size_class <= '0;
		req_ch.handle     <= '0;
		arst_n = 1'b0;
		cycle_count = 0;
		err_count = 0;
		words_sent = 0;
		words_checked = 0;
		reuse_grants = 0;
		pace_on = 1'b1;
		tbl_count = 0;
		tbl_live = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;
		foreach (tbl_free[i]) begin
			tbl_free[i] = 1'b0;
			tbl_class[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_first_and_append();
		test_memory_limit();
		test_fill_table();
		test_table_full_reuse();
		req_ch.valid <= 1'b0;

		// drain, then watch for stray responses
		wait (owed_rsp.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (owed_rsp.size() > 0) begin
			last_answer = owed_rsp.pop_front();
			report_mismatch("missing response status", -1, int'(last_answer.status));
		end

		$display("tb: %0d requests answered; ok %0d, no memory %0d, table full %0d,",
			words_checked, status_seen[ST_OK], status_seen[ST_NOMEM], status_seen[ST_FULL]);
		$display("tb: unavailable %0d, reuse grants %0d, %0d mismatches",
			status_seen[ST_UNAVAIL], reuse_grants, err_count);
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
